FILE: sv/attc_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// attc_pkg
// Shared types and constants for the text terminal core.
// ----------------------------------------------------------------------------
package attc_pkg;

   localparam int Rows         = 30;
   localparam int Cols         = 100;
   localparam int MaxCsiValues = 8;
   localparam int TabStop      = 8;
   localparam int Cells        = Rows * Cols;

   localparam int RowW   = 5;
   localparam int ColW   = 7;
   localparam int AddrW  = $clog2(Cells);
   localparam int CntW   = $clog2(MaxCsiValues + 1);
   localparam int IdxW   = (MaxCsiValues > 1) ? $clog2(MaxCsiValues) : 1;

   localparam logic [7:0] ChEsc   = 8'h1B;
   localparam logic [7:0] ChSpace = 8'h20;
   localparam logic [7:0] ChDel   = 8'h7F;
   localparam logic [7:0] ChBel   = 8'h07;
   localparam logic [7:0] ChLf    = 8'h0A;
   localparam logic [7:0] ChCr    = 8'h0D;
   localparam logic [7:0] ChBs    = 8'h08;
   localparam logic [7:0] ChTab   = 8'h09;

   typedef enum logic [1:0] {
      FUNC_FEED = 2'd0,
      FUNC_READ = 2'd1,
      FUNC_SPAN = 2'd2,
      FUNC_NONE = 2'd3
   } func_type;

   typedef enum logic [2:0] {
      PM_GROUND, PM_ESC, PM_CSI, PM_OSC, PM_OSC_ESC
   } pmode_type;

   typedef enum logic [2:0] {
      ST_IDLE,   // wait for request
      ST_FEED,   // single cell written / control op
      ST_READ,   // grid read in flight
      ST_SWEEP,  // walking cells: blank or scroll copy
      ST_SCRD,   // scroll: read cell below
      ST_RESP    // result waiting
   } state_type;

   typedef struct packed {
      logic [1:0]      func;
      logic [7:0]      byte_in;
      logic            end_of_write;
      logic [RowW-1:0] read_row;
      logic [ColW-1:0] read_col;
   } req_type;

   typedef struct packed {
      logic [RowW-1:0] cursor_row;
      logic [ColW-1:0] cursor_column;
      logic [7:0]      cell_char;
      logic            any_dirty;
      logic            full_refresh;
      logic            span_valid;
      logic [RowW-1:0] span_first;
      logic [RowW-1:0] span_last;
      logic            burst_done;
   } rsp_type;

   typedef struct packed {
      logic             we;
      logic [AddrW-1:0] waddr;
      logic [7:0]       wdata;
      logic [AddrW-1:0] raddr;
   } gmem_ctl_type;

endpackage
`default_nettype wire

FILE: sv/attc_grid.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// attc_grid
// Character grid memory: one write port, one registered read port.
// ----------------------------------------------------------------------------
module attc_grid (
   input  wire logic                   clock,
   input  wire attc_pkg::gmem_ctl_type ctl,
   output      logic [7:0]             rdata
);
   import attc_pkg::*;

   logic [7:0] mem [Cells];

   always_ff @(posedge clock) begin
      if (ctl.we) begin
         mem[ctl.waddr] <= ctl.wdata;
      end
      rdata <= mem[ctl.raddr];
   end

endmodule
`default_nettype wire

FILE: sv/ansi_text_terminal_core.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ansi_text_terminal_core
// Byte-fed character terminal with escape parser and dirty-row tracking.
// ----------------------------------------------------------------------------
// One request in, one response out. The 30x100 grid sits in a single-port-
// write RAM with registered reads. After reset the block clears all 3000
// cells, one cell per cycle, before taking requests. A feed byte, cell read
// or span request passes through ST_FEED or ST_READ into the response
// register. Erases walk one cell per cycle over the affected cells, J2 and
// ESC c walk all 3000 cells, and a scroll copies 2900 cells (read below,
// then write) and then blanks the last 100; the RAM port is the limit in
// every case. Responses are held until rsp_stall drops.
// ----------------------------------------------------------------------------
module ansi_text_terminal_core (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   output      logic              req_stall,
   input  wire attc_pkg::req_type req_data,
   output      logic              rsp_valid,
   input  wire logic              rsp_stall,
   output      attc_pkg::rsp_type rsp_data
);
   import attc_pkg::*;

   // ------------------------------------------------------------------ state
   state_type  state_ff, state_in;
   req_type    req_ff, req_in;
   rsp_type    rsp_ff, rsp_in;
   logic [RowW-1:0] row_ff, row_in;
   logic [ColW-1:0] col_ff, col_in;
   pmode_type  pm_ff, pm_in;
   logic [15:0] csi_ff [MaxCsiValues];
   logic [15:0] csi_in [MaxCsiValues];
   logic [CntW-1:0] cnt_ff, cnt_in;
   logic digit_ff, digit_in, priv_ff, priv_in, redraw_ff, redraw_in;
   logic [Rows-1:0] marks_ff, marks_in;
   logic init_ff, init_in;
   // sweep: blank cells [ptr, end), scroll copy when scroll set
   logic [AddrW-1:0] ptr_ff, ptr_in, end_ff, end_in;
   logic scroll_ff, scroll_in;
   // after scroll, a printable byte still has to land
   logic pend_ff, pend_in;

   gmem_ctl_type gctl;
   logic [7:0]   grd;

   attc_grid u_grid (.clock(clock), .ctl(gctl), .rdata(grd));

   assign req_stall = (state_ff != ST_IDLE) || init_ff;
   assign rsp_valid = (state_ff == ST_RESP);
   assign rsp_data  = rsp_ff;

   logic req_xfer;
   assign req_xfer = req_valid && !req_stall;

   function automatic logic [AddrW-1:0] cell_addr(input logic [RowW-1:0] r,
                                                  input logic [ColW-1:0] c);
      logic [AddrW+ColW-1:0] p;
      p = AddrW'(r) * AddrW'(Cols) + AddrW'(c);
      return p[AddrW-1:0];
   endfunction

   // ---------------------------------------------------------- csi helpers
   logic [15:0] v0, v1, n0, n1;
   logic [16:0] sum;
   always_comb begin
      v0 = (cnt_ff >= CntW'(1)) ? csi_ff[0] : 16'd0;
      v1 = (cnt_ff >= CntW'(2) && MaxCsiValues > 1) ? csi_ff[IdxW'(1 % MaxCsiValues)] : 16'd0;
      n0 = (v0 == 16'd0) ? 16'd1 : v0;
      n1 = (v1 == 16'd0) ? 16'd1 : v1;
      sum = 17'(n0);
   end

   // ----------------------------------------------------------- main logic
   always_comb begin
      logic [7:0]  c;
      logic [CntW-1:0] k;
      logic [16:0] t;
      logic [19:0] prod;
      logic [ColW:0] nx;
      logic [AddrW-1:0] rowbase;
      state_in  = state_ff;
      req_in    = req_ff;
      rsp_in    = rsp_ff;
      row_in    = row_ff;
      col_in    = col_ff;
      pm_in     = pm_ff;
      csi_in    = csi_ff;
      cnt_in    = cnt_ff;
      digit_in  = digit_ff;
      priv_in   = priv_ff;
      redraw_in = redraw_ff;
      marks_in  = marks_ff;
      init_in   = init_ff;
      ptr_in    = ptr_ff;
      end_in    = end_ff;
      scroll_in = scroll_ff;
      pend_in   = pend_ff;
      gctl.we    = 1'b0;
      gctl.waddr = ptr_ff;
      gctl.wdata = ChSpace;
      gctl.raddr = cell_addr(req_ff.read_row, req_ff.read_col);
      c = req_ff.byte_in;
      k = '0;
      t = '0;
      prod = '0;
      nx = '0;
      rowbase = cell_addr(row_ff, '0);

      case (state_ff)
         ST_IDLE: begin
            if (init_ff) begin
               gctl.we = 1'b1;
               ptr_in  = ptr_ff + AddrW'(1);
               if (ptr_ff == AddrW'(Cells - 1)) begin
                  init_in = 1'b0;
               end
            end else if (req_xfer) begin
               req_in = req_data;
               // start the cell read on the accepting edge
               gctl.raddr = cell_addr(req_data.read_row, req_data.read_col);
               case (func_type'(req_data.func))
                  FUNC_FEED: state_in = ST_FEED;
                  FUNC_READ: state_in = ST_READ;
                  default:   state_in = ST_FEED;
               endcase
            end
         end

         ST_READ: begin
            state_in = ST_RESP;
         end

         ST_FEED: begin
            state_in = ST_RESP;
            if (func_type'(req_ff.func) == FUNC_FEED) begin
               case (pm_ff)
                  PM_GROUND: begin
                     if (c == ChEsc) begin
                        pm_in = PM_ESC;
                     end else if (c >= ChSpace && c < ChDel) begin
                        if (col_ff >= ColW'(Cols)) begin
                           col_in = '0;
                           if (row_ff == RowW'(Rows - 1)) begin
                              // scroll, then print on return
                              scroll_in = 1'b1;
                              pend_in   = 1'b1;
                              ptr_in    = '0;
                              end_in    = AddrW'(Cells - Cols);
                              marks_in  = '1;
                              redraw_in = 1'b1;
                              state_in  = ST_SCRD;
                           end else begin
                              row_in = row_ff + RowW'(1);
                              gctl.we    = 1'b1;
                              gctl.waddr = cell_addr(row_ff + RowW'(1), '0);
                              gctl.wdata = c;
                              marks_in[row_ff + RowW'(1)] = 1'b1;
                              col_in = ColW'(1);
                           end
                        end else begin
                           gctl.we    = 1'b1;
                           gctl.waddr = cell_addr(row_ff, col_ff);
                           gctl.wdata = c;
                           marks_in[row_ff] = 1'b1;
                           col_in = col_ff + ColW'(1);
                        end
                     end else if (c == ChLf) begin
                        col_in = '0;
                        if (row_ff == RowW'(Rows - 1)) begin
                           scroll_in = 1'b1;
                           ptr_in    = '0;
                           end_in    = AddrW'(Cells - Cols);
                           marks_in  = '1;
                           redraw_in = 1'b1;
                           state_in  = ST_SCRD;
                        end else begin
                           row_in = row_ff + RowW'(1);
                        end
                     end else if (c == ChCr) begin
                        col_in = '0;
                     end else if (c == ChBs) begin
                        if (col_ff != '0) col_in = col_ff - ColW'(1);
                     end else if (c == ChTab) begin
                        nx = (ColW+1)'((col_ff / ColW'(TabStop) + ColW'(1)) * ColW'(TabStop));
                        col_in = (nx >= (ColW+1)'(Cols)) ? ColW'(Cols - 1) : nx[ColW-1:0];
                     end
                  end
                  PM_ESC: begin
                     if (c == "[") begin
                        pm_in    = PM_CSI;
                        cnt_in   = '0;
                        digit_in = 1'b0;
                        priv_in  = 1'b0;
                        csi_in[0] = '0;
                     end else if (c == "]") begin
                        pm_in = PM_OSC;
                     end else if (c == "c") begin
                        pm_in     = PM_GROUND;
                        row_in    = '0;
                        col_in    = '0;
                        cnt_in    = '0;
                        digit_in  = 1'b0;
                        priv_in   = 1'b0;
                        redraw_in = 1'b1;
                        marks_in  = '1;
                        ptr_in    = '0;
                        end_in    = AddrW'(Cells);
                        state_in  = ST_SWEEP;
                     end else begin
                        pm_in = PM_GROUND;
                     end
                  end
                  PM_CSI: begin
                     if (c >= "0" && c <= "9") begin
                        k = cnt_ff;
                        if (!digit_ff && cnt_ff < CntW'(MaxCsiValues)) begin
                           csi_in[IdxW'(cnt_ff)] = '0;
                           k = cnt_ff + CntW'(1);
                           cnt_in = k;
                           digit_in = 1'b1;
                        end
                        if ((digit_ff || cnt_ff < CntW'(MaxCsiValues)) && k >= CntW'(1)) begin
                           prod = (!digit_ff && cnt_ff < CntW'(MaxCsiValues)) ? 20'd0 :
                                  20'(csi_ff[IdxW'(k - CntW'(1))]) * 20'd10;
                           csi_in[IdxW'(k - CntW'(1))] =
                              16'(prod + 20'(c - "0"));
                        end
                     end else if (c == ";") begin
                        if (!digit_ff && cnt_ff < CntW'(MaxCsiValues)) begin
                           csi_in[IdxW'(cnt_ff)] = '0;
                           cnt_in = cnt_ff + CntW'(1);
                        end
                        digit_in = 1'b0;
                     end else if (c == "?" || c == ">" || c == "<" || c == "=") begin
                        priv_in = 1'b1;
                     end else if (c >= 8'h40 && c <= 8'h7E) begin
                        pm_in = PM_GROUND;
                        if (!priv_ff) begin
                           case (c)
                              "H", "f": begin
                                 row_in = (n0 > 16'(Rows)) ? RowW'(Rows - 1) :
                                          RowW'(n0 - 16'd1);
                                 col_in = (n1 > 16'(Cols)) ? ColW'(Cols - 1) :
                                          ColW'(n1 - 16'd1);
                              end
                              "A": row_in = (n0 >= 16'(row_ff)) ? '0 :
                                            row_ff - RowW'(n0);
                              "B": begin
                                 t = sum + 17'(row_ff);
                                 row_in = (t >= 17'(Rows)) ? RowW'(Rows - 1) : RowW'(t);
                              end
                              "C": begin
                                 t = sum + 17'(col_ff);
                                 col_in = (t >= 17'(Cols)) ? ColW'(Cols - 1) : ColW'(t);
                              end
                              "D": col_in = (n0 >= 16'(col_ff)) ? '0 :
                                            col_ff - ColW'(n0);
                              "J": begin
                                 if (v0 == 16'd2) begin
                                    marks_in  = '1;
                                    redraw_in = 1'b1;
                                    ptr_in = '0;
                                    end_in = AddrW'(Cells);
                                    state_in = ST_SWEEP;
                                 end else if (v0 == 16'd0) begin
                                    for (int r = 0; r < Rows; r++)
                                       if (RowW'(r) >= row_ff) marks_in[r] = 1'b1;
                                    ptr_in = (col_ff >= ColW'(Cols)) ?
                                             rowbase + AddrW'(Cols) :
                                             rowbase + AddrW'(col_ff);
                                    end_in = AddrW'(Cells);
                                    state_in = ST_SWEEP;
                                 end else if (v0 == 16'd1) begin
                                    for (int r = 0; r < Rows; r++)
                                       if (RowW'(r) <= row_ff) marks_in[r] = 1'b1;
                                    ptr_in = '0;
                                    end_in = (col_ff >= ColW'(Cols)) ?
                                             rowbase + AddrW'(Cols) :
                                             rowbase + AddrW'(col_ff) + AddrW'(1);
                                    state_in = ST_SWEEP;
                                 end
                              end
                              "K": begin
                                 if (v0 <= 16'd2) begin
                                    marks_in[row_ff] = 1'b1;
                                    state_in = ST_SWEEP;
                                    ptr_in = rowbase;
                                    end_in = rowbase + AddrW'(Cols);
                                    if (v0 == 16'd0) begin
                                       ptr_in = (col_ff >= ColW'(Cols)) ?
                                                rowbase + AddrW'(Cols) :
                                                rowbase + AddrW'(col_ff);
                                    end else if (v0 == 16'd1) begin
                                       end_in = (col_ff >= ColW'(Cols)) ?
                                                rowbase + AddrW'(Cols) :
                                                rowbase + AddrW'(col_ff) + AddrW'(1);
                                    end
                                 end
                              end
                              default: ;
                           endcase
                        end
                     end
                  end
                  PM_OSC: begin
                     if (c == ChBel) pm_in = PM_GROUND;
                     else if (c == ChEsc) pm_in = PM_OSC_ESC;
                  end
                  default: begin
                     pm_in = (c == "\\") ? PM_GROUND : PM_OSC;
                  end
               endcase
            end
         end

         // scroll copy: read cell one row below
         ST_SCRD: begin
            if (ptr_ff >= end_ff) begin
               scroll_in = 1'b0;
               end_in    = AddrW'(Cells);
               state_in  = ST_SWEEP;
            end else begin
               gctl.raddr = ptr_ff + AddrW'(Cols);
               state_in   = ST_SWEEP;
            end
         end

         ST_SWEEP: begin
            if (scroll_ff) begin
               gctl.we    = 1'b1;
               gctl.wdata = grd;
               ptr_in     = ptr_ff + AddrW'(1);
               state_in   = ST_SCRD;
            end else if (ptr_ff >= end_ff) begin
               if (pend_ff) begin
                  pend_in    = 1'b0;
                  gctl.we    = 1'b1;
                  gctl.waddr = cell_addr(row_ff, '0);
                  gctl.wdata = c;
                  col_in     = ColW'(1);
               end
               state_in = ST_RESP;
            end else begin
               gctl.we = 1'b1;
               ptr_in  = ptr_ff + AddrW'(1);
            end
         end

         ST_RESP: begin
            if (!rsp_stall) state_in = ST_IDLE;
         end

         default: state_in = ST_IDLE;
      endcase

      // response capture on the way into ST_RESP
      if (state_ff != ST_RESP && state_in == ST_RESP) begin
         rsp_in = '0;
         rsp_in.cursor_row    = row_in;
         rsp_in.cursor_column = col_in;
         rsp_in.burst_done    = req_ff.end_of_write;
         rsp_in.full_refresh  = redraw_in;
         if (state_ff == ST_READ) begin
            rsp_in.cell_char = (req_ff.read_row < RowW'(Rows) &&
                                req_ff.read_col < ColW'(Cols)) ? grd : 8'd0;
         end
         if (func_type'(req_ff.func) == FUNC_SPAN) begin
            rsp_in.span_valid = |marks_ff;
            for (int r = Rows - 1; r >= 0; r--)
               if (marks_ff[r]) rsp_in.span_first = RowW'(r);
            for (int r = 0; r < Rows; r++)
               if (marks_ff[r]) rsp_in.span_last = RowW'(r);
            marks_in  = '0;
            redraw_in = 1'b0;
         end
         rsp_in.any_dirty = |marks_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_IDLE;
         row_ff    <= '0;
         col_ff    <= '0;
         pm_ff     <= PM_GROUND;
         cnt_ff    <= '0;
         digit_ff  <= 1'b0;
         priv_ff   <= 1'b0;
         redraw_ff <= 1'b1;
         marks_ff  <= '1;
         init_ff   <= 1'b1;
         ptr_ff    <= '0;
         end_ff    <= '0;
         scroll_ff <= 1'b0;
         pend_ff   <= 1'b0;
      end else begin
         state_ff  <= state_in;
         row_ff    <= row_in;
         col_ff    <= col_in;
         pm_ff     <= pm_in;
         cnt_ff    <= cnt_in;
         digit_ff  <= digit_in;
         priv_ff   <= priv_in;
         redraw_ff <= redraw_in;
         marks_ff  <= marks_in;
         init_ff   <= init_in;
         ptr_ff    <= ptr_in;
         end_ff    <= end_in;
         scroll_ff <= scroll_in;
         pend_ff   <= pend_in;
      end
      req_ff <= req_in;
      rsp_ff <= rsp_in;
      csi_ff <= csi_in;
   end

endmodule
`default_nettype wire

FILE: sv/attc_checker.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// attc_checker
// Port-level checks for the terminal core.
// ----------------------------------------------------------------------------
module attc_port_checks (
   input wire logic              clock,
   input wire logic              reset,
   input wire logic              req_stall,
   input wire logic              rsp_valid,
   input wire logic              rsp_stall,
   input wire attc_pkg::rsp_type rsp_data
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
      else $error("response changed while stalled");

   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> req_stall)
      else $error("request taken while response pending");

   a_span_clears: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.span_valid |-> !rsp_data.any_dirty)
      else $error("marks not cleared by span transfer");

   a_span_order: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.span_valid |-> rsp_data.span_first <= rsp_data.span_last)
      else $error("span bounds out of order");

endmodule

bind ansi_text_terminal_core attc_port_checks u_attc_port_checks (.*);
`default_nettype wire
